[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion shorthands, sampled on clk and disabled during arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[rtl/ctil_pkg.sv]
// ----------------------------------------------------------------------------
// ctil_pkg
// shared codes, command and status types for the complex table lookup
// ----------------------------------------------------------------------------
`default_nettype none

package ctil_pkg;

	// input item modes
	localparam logic [1:0] MODE_ID     = 2'd0;
	localparam logic [1:0] MODE_SAMPLE = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;

	// requested quantity
	localparam logic [1:0] KIND_RE    = 2'd0;
	localparam logic [1:0] KIND_IM    = 2'd1;
	localparam logic [1:0] KIND_MAG   = 2'd2;
	localparam logic [1:0] KIND_PHASE = 2'd3;

	// result status
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_RANGE     = 2'd2;

	// register indexes
	localparam logic REG_LINES_IN_USE = 1'b0;
	localparam logic REG_STEP_RECIP   = 1'b1;

	localparam logic [15:0] STEP_RECIP_RST = 16'd4096;
	localparam logic [20:0] HALF_PI_Q20    = 21'd1647099;

	// datapath operations
	localparam logic [4:0] OP_NONE     = 5'd0;
	localparam logic [4:0] OP_LOAD     = 5'd1;
	localparam logic [4:0] OP_SRCH     = 5'd2;
	localparam logic [4:0] OP_CHK      = 5'd3;
	localparam logic [4:0] OP_RDA      = 5'd4;
	localparam logic [4:0] OP_RDB      = 5'd5;
	localparam logic [4:0] OP_RDW      = 5'd6;
	localparam logic [4:0] OP_NEAR     = 5'd7;
	localparam logic [4:0] OP_L1       = 5'd8;
	localparam logic [4:0] OP_L2       = 5'd9;
	localparam logic [4:0] OP_L3       = 5'd10;
	localparam logic [4:0] OP_SQ1      = 5'd11;
	localparam logic [4:0] OP_SQ2      = 5'd12;
	localparam logic [4:0] OP_SQ3      = 5'd13;
	localparam logic [4:0] OP_SQRT     = 5'd14;
	localparam logic [4:0] OP_CINIT    = 5'd15;
	localparam logic [4:0] OP_CORD     = 5'd16;
	localparam logic [4:0] OP_RES_RE   = 5'd17;
	localparam logic [4:0] OP_RES_IM   = 5'd18;
	localparam logic [4:0] OP_RES_MAG  = 5'd19;
	localparam logic [4:0] OP_RES_PH   = 5'd20;
	localparam logic [4:0] OP_RES_ZERO = 5'd21;
	localparam logic [4:0] OP_RES_NF   = 5'd22;
	localparam logic [4:0] OP_RES_RNG  = 5'd23;

	typedef struct packed {
		logic [4:0] op;
		logic       issue;   // read one line id at the iteration index
	} cmd_t;

	typedef struct packed {
		logic       match;
		logic       id_vld;
		logic       range_bad;
		logic       lin;
		logic [1:0] kind;
		logic       zero;
	} sts_t;

	// cordic angle table, atan(2^-i) in q.20
	function automatic logic [19:0] atan_q20(input logic [4:0] i);
		logic [19:0] a;
		case (i)
			5'd0:    a = 20'd823550;
			5'd1:    a = 20'd486170;
			5'd2:    a = 20'd256879;
			5'd3:    a = 20'd130396;
			5'd4:    a = 20'd65451;
			5'd5:    a = 20'd32757;
			5'd6:    a = 20'd16383;
			5'd7:    a = 20'd8192;
			5'd8:    a = 20'd4096;
			5'd9:    a = 20'd2048;
			5'd10:   a = 20'd1024;
			5'd11:   a = 20'd512;
			5'd12:   a = 20'd256;
			5'd13:   a = 20'd128;
			5'd14:   a = 20'd64;
			5'd15:   a = 20'd32;
			5'd16:   a = 20'd16;
			5'd17:   a = 20'd8;
			5'd18:   a = 20'd4;
			5'd19:   a = 20'd2;
			default: a = 20'd0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

[rtl/ctil_ctrl.sv]
// ----------------------------------------------------------------------------
// ctil_ctrl
// sequencer: line search, sample fetch, interpolation, sqrt and cordic steps
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ctil_ctrl #(
	parameter int MAX_LINES = 64,
	parameter int CW        = 7
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [1:0]       mode,
	input  wire logic [6:0]       lines_in_use,
	input  wire ctil_pkg::sts_t   sts,
	output ctil_pkg::cmd_t        cmd,
	output logic [CW-1:0]         cnt,
	output logic                  busy,
	output logic                  done
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_SRCH = 5'd1;
	localparam logic [4:0] S_CHK  = 5'd2;
	localparam logic [4:0] S_RDA  = 5'd3;
	localparam logic [4:0] S_RDB  = 5'd4;
	localparam logic [4:0] S_RDW  = 5'd5;
	localparam logic [4:0] S_NEAR = 5'd6;
	localparam logic [4:0] S_L1   = 5'd7;
	localparam logic [4:0] S_L2   = 5'd8;
	localparam logic [4:0] S_L3   = 5'd9;
	localparam logic [4:0] S_KIND = 5'd10;
	localparam logic [4:0] S_SQ1  = 5'd11;
	localparam logic [4:0] S_SQ2  = 5'd12;
	localparam logic [4:0] S_SQ3  = 5'd13;
	localparam logic [4:0] S_SQRT = 5'd14;
	localparam logic [4:0] S_MAGO = 5'd15;
	localparam logic [4:0] S_CORD = 5'd16;
	localparam logic [4:0] S_PHO  = 5'd17;
	localparam logic [4:0] S_DONE = 5'd18;

	localparam logic [CW-1:0] SQRT_LAST = CW'(31);
	localparam logic [CW-1:0] CORD_LAST = CW'(19);

	logic [4:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          more;

	// search continues while below both the register and the table depth
	assign more = (cnt_q < CW'(lines_in_use)) && (cnt_q < CW'(MAX_LINES));

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		cmd.op    = ctil_pkg::OP_NONE;
		cmd.issue = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op = ctil_pkg::OP_LOAD;
					if (mode == ctil_pkg::MODE_QUERY) begin
						state_d = S_SRCH;
						cnt_d   = '0;
					end
				end
			end
			S_SRCH: begin
				cmd.op = ctil_pkg::OP_SRCH;
				if (sts.match) begin
					state_d = S_CHK;
				end else if (more) begin
					cmd.issue = 1'b1;
					cnt_d     = cnt_q + CW'(1);
				end else if (!sts.id_vld) begin
					cmd.op  = ctil_pkg::OP_RES_NF;
					state_d = S_DONE;
				end
			end
			S_CHK: begin
				if (sts.range_bad) begin
					cmd.op  = ctil_pkg::OP_RES_RNG;
					state_d = S_DONE;
				end else begin
					cmd.op  = ctil_pkg::OP_CHK;
					state_d = S_RDA;
				end
			end
			S_RDA: begin
				cmd.op  = ctil_pkg::OP_RDA;
				state_d = S_RDB;
			end
			S_RDB: begin
				cmd.op  = ctil_pkg::OP_RDB;
				state_d = sts.lin ? S_RDW : S_NEAR;
			end
			S_RDW: begin
				cmd.op  = ctil_pkg::OP_RDW;
				state_d = S_L1;
			end
			S_NEAR: begin
				cmd.op  = ctil_pkg::OP_NEAR;
				state_d = S_KIND;
			end
			S_L1: begin
				cmd.op  = ctil_pkg::OP_L1;
				state_d = S_L2;
			end
			S_L2: begin
				cmd.op  = ctil_pkg::OP_L2;
				state_d = S_L3;
			end
			S_L3: begin
				cmd.op  = ctil_pkg::OP_L3;
				state_d = S_KIND;
			end
			S_KIND: begin
				cnt_d = '0;
				unique case (sts.kind)
					ctil_pkg::KIND_RE: begin
						cmd.op  = ctil_pkg::OP_RES_RE;
						state_d = S_DONE;
					end
					ctil_pkg::KIND_IM: begin
						cmd.op  = ctil_pkg::OP_RES_IM;
						state_d = S_DONE;
					end
					ctil_pkg::KIND_MAG: begin
						cmd.op  = ctil_pkg::OP_SQ1;
						state_d = S_SQ2;
					end
					default: begin
						if (sts.zero) begin
							cmd.op  = ctil_pkg::OP_RES_ZERO;
							state_d = S_DONE;
						end else begin
							cmd.op  = ctil_pkg::OP_CINIT;
							state_d = S_CORD;
						end
					end
				endcase
			end
			S_SQ1: begin
				cmd.op  = ctil_pkg::OP_SQ1;
				state_d = S_SQ2;
			end
			S_SQ2: begin
				cmd.op  = ctil_pkg::OP_SQ2;
				state_d = S_SQ3;
			end
			S_SQ3: begin
				cmd.op  = ctil_pkg::OP_SQ3;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = ctil_pkg::OP_SQRT;
				if (cnt_q == SQRT_LAST) begin
					state_d = S_MAGO;
				end else begin
					cnt_d = cnt_q + CW'(1);
				end
			end
			S_MAGO: begin
				cmd.op  = ctil_pkg::OP_RES_MAG;
				state_d = S_DONE;
			end
			S_CORD: begin
				cmd.op = ctil_pkg::OP_CORD;
				if (cnt_q == CORD_LAST) begin
					state_d = S_PHO;
				end else begin
					cnt_d = cnt_q + CW'(1);
				end
			end
			S_PHO: begin
				cmd.op  = ctil_pkg::OP_RES_PH;
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign cnt  = cnt_q;
	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	`AST_IMPL(a_done_after_busy, done, $past(busy))
	`AST_NEXT(a_done_single, done, !done)
	`AST_NEXT(a_query_goes_busy, start && !busy && mode == ctil_pkg::MODE_QUERY, busy)
	`AST_IMPL(a_issue_in_range, cmd.issue, cnt < CW'(MAX_LINES))

endmodule

`default_nettype wire

[rtl/ctil_dp.sv]
// ----------------------------------------------------------------------------
// ctil_dp
// datapath: line id and sample memories, interpolation, sqrt and cordic
// ----------------------------------------------------------------------------
`default_nettype none

module ctil_dp #(
	parameter int MAX_LINES      = 64,
	parameter int RADIUS_SAMPLES = 256,
	parameter int SAMPLE_BITS    = 24,
	parameter int CW             = 7
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ctil_pkg::cmd_t      cmd,
	input  wire logic [CW-1:0]       cnt,
	output ctil_pkg::sts_t           sts,
	input  wire logic [15:0]         step_recip,
	input  wire logic [1:0]          mode,
	input  wire logic [5:0]          line_slot,
	input  wire logic [7:0]          radius_slot,
	input  wire logic signed [23:0]  sample_re,
	input  wire logic signed [23:0]  sample_im,
	input  wire logic signed [5:0]   order_n,
	input  wire logic [7:0]          order_l,
	input  wire logic [23:0]         radius,
	input  wire logic [1:0]          kind,
	input  wire logic                interp,
	output logic signed [31:0]       value,
	output logic [1:0]               status
);

	localparam int SB    = SAMPLE_BITS;
	localparam int LW    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int RW    = $clog2(RADIUS_SAMPLES);
	localparam int DEPTH = MAX_LINES * RADIUS_SAMPLES;
	localparam int AW    = $clog2(DEPTH);

	logic [13:0]       id_mem [MAX_LINES];
	logic [2*SB-1:0]   smem   [DEPTH];

	logic [13:0]       key_q;
	logic [23:0]       radius_q;
	logic [1:0]        kind_q;
	logic              interp_q;
	logic [39:0]       p_q;
	logic [13:0]       id_rd_q;
	logic [LW-1:0]     id_idx_q;
	logic              id_vld_q;
	logic [LW-1:0]     line_q;
	logic [AW-1:0]     addr_q;
	logic [2*SB-1:0]   rd_q, a_q, b_q;
	logic signed [32:0] re_q, im_q;
	logic signed [49:0] prod_q;
	logic [63:0]       pa_q, pb_q, v_q, r_q, bitw_q;
	logic signed [43:0] x_q, y_q;
	logic signed [25:0] z_q;
	logic signed [31:0] val_q;
	logic [1:0]        st_q;

	logic [LW+5:0]     ls_ext;
	logic [RW+7:0]     rs_ext;
	logic [AW-1:0]     waddr;
	logic [31:0]       wre, wim;
	logic [40:0]       p_rnd;
	logic [16:0]       idx_near, idx_lin, sidx;
	logic signed [32:0] are, aim, bre, bim, dre, dim, lin_a;
	logic signed [16:0] t_s;
	logic signed [50:0] lin_s;
	logic [31:0]       abs_re, abs_im;
	logic [63:0]       rb;
	logic [4:0]        sh;
	logic signed [43:0] dx, dy;
	logic signed [25:0] at, z_rnd, z_sh;

	function automatic logic [31:0] abs33(input logic signed [32:0] x);
		logic signed [32:0] m;
		m = (x < 0) ? -x : x;
		return m[31:0];
	endfunction

	assign ls_ext = {{LW{1'b0}}, line_slot};
	assign rs_ext = {{RW{1'b0}}, radius_slot};
	assign waddr  = AW'(ls_ext[LW-1:0] * RADIUS_SAMPLES + rs_ext[RW-1:0]);
	assign wre    = {8'd0, sample_re};
	assign wim    = {8'd0, sample_im};

	assign p_rnd    = {1'b0, p_q} + 41'(40'd1 << 23);
	assign idx_near = p_rnd[40:24];
	assign idx_lin  = {1'b0, p_q[39:24]};
	assign sidx     = interp_q ? idx_lin : idx_near;

	assign are   = 33'(signed'(a_q[SB-1:0]));
	assign aim   = 33'(signed'(a_q[2*SB-1:SB]));
	assign bre   = 33'(signed'(b_q[SB-1:0]));
	assign bim   = 33'(signed'(b_q[2*SB-1:SB]));
	assign dre   = bre - are;
	assign dim   = bim - aim;
	assign t_s   = signed'({1'b0, p_q[23:8]});
	assign lin_a = (cmd.op == ctil_pkg::OP_L2) ? are : aim;
	assign lin_s = (51'(lin_a) <<< 16) + 51'(prod_q) + 51'(32768);

	assign abs_re = abs33(re_q);
	assign abs_im = abs33(im_q);
	assign rb     = r_q + bitw_q;

	assign sh    = cnt[4:0];
	assign dx    = y_q >>> sh;
	assign dy    = x_q >>> sh;
	assign at    = 26'(ctil_pkg::atan_q20(sh));
	assign z_rnd = z_q + 26'sd64;
	assign z_sh  = z_rnd >>> 7;

	assign sts.match     = id_vld_q && (id_rd_q == key_q);
	assign sts.id_vld    = id_vld_q;
	assign sts.range_bad = interp_q ? ((idx_lin + 17'd1) >= 17'(RADIUS_SAMPLES))
	                                : (idx_near >= 17'(RADIUS_SAMPLES));
	assign sts.lin       = interp_q;
	assign sts.kind      = kind_q;
	assign sts.zero      = (re_q == 0) && (im_q == 0);

	// line id memory with registered read
	always_ff @(posedge clk) begin
		if (cmd.op == ctil_pkg::OP_LOAD && mode == ctil_pkg::MODE_ID &&
		    ls_ext < (LW+6)'(MAX_LINES)) begin
			id_mem[ls_ext[LW-1:0]] <= {order_n, order_l};
		end
		if (cmd.issue) begin
			id_rd_q  <= id_mem[cnt[LW-1:0]];
			id_idx_q <= cnt[LW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_vld_q <= 1'b0;
		end else begin
			id_vld_q <= cmd.issue;
		end
	end

	// sample memory, one port
	always_ff @(posedge clk) begin
		if (cmd.op == ctil_pkg::OP_LOAD && mode == ctil_pkg::MODE_SAMPLE &&
		    ls_ext < (LW+6)'(MAX_LINES) && rs_ext < (RW+8)'(RADIUS_SAMPLES)) begin
			smem[waddr] <= {wim[SB-1:0], wre[SB-1:0]};
		end
		if (cmd.op == ctil_pkg::OP_RDA) begin
			rd_q <= smem[addr_q];
		end else if (cmd.op == ctil_pkg::OP_RDB && interp_q) begin
			rd_q <= smem[AW'(addr_q + AW'(1))];
		end
	end

	always_ff @(posedge clk) begin
		p_q <= 40'(radius_q) * 40'(step_recip);
		unique case (cmd.op)
			ctil_pkg::OP_LOAD: begin
				key_q    <= {order_n, order_l};
				radius_q <= radius;
				kind_q   <= kind;
				interp_q <= interp;
			end
			ctil_pkg::OP_SRCH: begin
				if (sts.match) begin
					line_q <= id_idx_q;
				end
			end
			ctil_pkg::OP_CHK: begin
				addr_q <= AW'(line_q * RADIUS_SAMPLES + sidx[RW-1:0]);
			end
			ctil_pkg::OP_RDB: begin
				a_q <= rd_q;
			end
			ctil_pkg::OP_RDW: begin
				b_q <= rd_q;
			end
			ctil_pkg::OP_NEAR: begin
				re_q <= are;
				im_q <= aim;
			end
			ctil_pkg::OP_L1: begin
				prod_q <= 50'(dre) * 50'(t_s);
			end
			ctil_pkg::OP_L2: begin
				re_q   <= lin_s[48:16];
				prod_q <= 50'(dim) * 50'(t_s);
			end
			ctil_pkg::OP_L3: begin
				im_q <= lin_s[48:16];
			end
			ctil_pkg::OP_SQ1: begin
				pa_q <= 64'(abs_re) * 64'(abs_re);
			end
			ctil_pkg::OP_SQ2: begin
				pb_q <= 64'(abs_im) * 64'(abs_im);
			end
			ctil_pkg::OP_SQ3: begin
				v_q    <= pa_q + pb_q;
				r_q    <= '0;
				bitw_q <= 64'd1 << 62;
			end
			ctil_pkg::OP_SQRT: begin
				if (v_q >= rb) begin
					v_q <= v_q - rb;
					r_q <= (r_q >> 1) + bitw_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bitw_q <= bitw_q >> 2;
			end
			ctil_pkg::OP_CINIT: begin
				// left half-plane folds by a quarter turn first
				if (re_q < 0) begin
					if (im_q >= 0) begin
						x_q <= 44'(im_q) <<< 8;
						y_q <= (-44'(re_q)) <<< 8;
						z_q <= 26'(ctil_pkg::HALF_PI_Q20);
					end else begin
						x_q <= (-44'(im_q)) <<< 8;
						y_q <= 44'(re_q) <<< 8;
						z_q <= -26'(ctil_pkg::HALF_PI_Q20);
					end
				end else begin
					x_q <= 44'(re_q) <<< 8;
					y_q <= 44'(im_q) <<< 8;
					z_q <= '0;
				end
			end
			ctil_pkg::OP_CORD: begin
				if (y_q >= 0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end
			end
			ctil_pkg::OP_RES_RE: begin
				val_q <= re_q[31:0];
				st_q  <= ctil_pkg::ST_OK;
			end
			ctil_pkg::OP_RES_IM: begin
				val_q <= im_q[31:0];
				st_q  <= ctil_pkg::ST_OK;
			end
			ctil_pkg::OP_RES_MAG: begin
				val_q <= r_q[31] ? 32'sh7FFF_FFFF : signed'(r_q[31:0]);
				st_q  <= ctil_pkg::ST_OK;
			end
			ctil_pkg::OP_RES_PH: begin
				val_q <= 32'(z_sh);
				st_q  <= ctil_pkg::ST_OK;
			end
			ctil_pkg::OP_RES_ZERO: begin
				val_q <= '0;
				st_q  <= ctil_pkg::ST_OK;
			end
			ctil_pkg::OP_RES_NF: begin
				val_q <= '0;
				st_q  <= ctil_pkg::ST_NOT_FOUND;
			end
			ctil_pkg::OP_RES_RNG: begin
				val_q <= '0;
				st_q  <= ctil_pkg::ST_RANGE;
			end
			default: begin
			end
		endcase
	end

	assign value  = val_q;
	assign status = st_q;

endmodule

`default_nettype wire

[rtl/complex_table_interp_lookup.sv]
// ----------------------------------------------------------------------------
// complex_table_interp_lookup
// complex sample table with line search, nearest or linear radius lookup,
// and real, imaginary, magnitude or phase output
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            payload
// config    in         cfg_we               cfg_idx, cfg_wdata
// item      in         start && !busy       mode .. interp
// result    out        done (one cycle)     value, status
//
// a load transaction produces no result
// query: the line search scans the lines in use until one matches or none does, then
// the radius is range-checked and the sample fetched, with interpolation for a
// linear lookup (no fetch when the radius is out of range), then re/im is output
// directly, magnitude after 32 sqrt steps, or phase after cordic (zero at the origin),
// and the done state follows; start waits while busy, done is a one-cycle strobe
// arst_n resets the sequencer and the config registers; both memories start undefined
//
`default_nettype none

module complex_table_interp_lookup #(
	parameter int MAX_LINES      = 64,
	parameter int RADIUS_SAMPLES = 256,
	parameter int SAMPLE_BITS    = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration write port
	input  wire logic               cfg_we,
	input  wire logic               cfg_idx,
	input  wire logic [15:0]        cfg_wdata,
	// item transaction
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         mode,
	input  wire logic [5:0]         line_slot,
	input  wire logic [7:0]         radius_slot,
	input  wire logic signed [23:0] sample_re,
	input  wire logic signed [23:0] sample_im,
	input  wire logic signed [5:0]  order_n,
	input  wire logic [7:0]         order_l,
	input  wire logic [23:0]        radius,
	input  wire logic [1:0]         kind,
	input  wire logic               interp,
	// result transaction
	output logic                    done,
	output logic signed [31:0]      value,
	output logic [1:0]              status
);

	// counter covers the line count and the 32 sqrt steps
	localparam int CL = $clog2(MAX_LINES + 1);
	localparam int CW = (CL > 7) ? CL : 7;

	logic [6:0]      lines_in_use_q;
	logic [15:0]     step_recip_q;
	ctil_pkg::cmd_t  cmd;
	ctil_pkg::sts_t  sts;
	logic [CW-1:0]   cnt;

	// configuration registers; the user must write them only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_in_use_q <= '0;
			step_recip_q   <= ctil_pkg::STEP_RECIP_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				ctil_pkg::REG_LINES_IN_USE: lines_in_use_q <= cfg_wdata[6:0];
				default:                    step_recip_q   <= cfg_wdata;
			endcase
		end
	end

	// sequencer
	ctil_ctrl #(
		.MAX_LINES (MAX_LINES),
		.CW        (CW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.mode         (mode),
		.lines_in_use (lines_in_use_q),
		.sts          (sts),
		.cmd          (cmd),
		.cnt          (cnt),
		.busy         (busy),
		.done         (done)
	);

	// memories and arithmetic
	ctil_dp #(
		.MAX_LINES      (MAX_LINES),
		.RADIUS_SAMPLES (RADIUS_SAMPLES),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.CW             (CW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cnt         (cnt),
		.sts         (sts),
		.step_recip  (step_recip_q),
		.mode        (mode),
		.line_slot   (line_slot),
		.radius_slot (radius_slot),
		.sample_re   (sample_re),
		.sample_im   (sample_im),
		.order_n     (order_n),
		.order_l     (order_l),
		.radius      (radius),
		.kind        (kind),
		.interp      (interp),
		.value       (value),
		.status      (status)
	);

endmodule

`default_nettype wire
